[sv/cft_pkg.sv]
`timescale 1ns / 1ps
// cft_pkg: shared types and constants for the csv field tokenizer
// no dependencies; used by all tokenizer modules

package cft_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    // step queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one result item as it leaves the block
    typedef struct packed {
        logic       has_byte;
        logic [7:0] field_byte;
        logic       field_end;
        logic       line_end;
    } result_t;

    // one classified byte: its first result plus a flag for the trailing empty field
    typedef struct packed {
        result_t first;
        logic    extra;
    } step_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[sv/cft_if.sv]
`timescale 1ns / 1ps
// cft_if: valid/ready channel interfaces for text bytes, results and configuration
// no dependencies

interface cft_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface cft_result_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] field_byte;
    logic       field_end;
    logic       line_end;

    modport source (output valid, output has_byte, output field_byte,
                    output field_end, output line_end, input ready);
    modport sink (input valid, input has_byte, input field_byte,
                  input field_end, input line_end, output ready);
endinterface

interface cft_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] delimiter;

    modport source (output valid, output delimiter, input ready);
    modport sink (input valid, input delimiter, output ready);
endinterface

[sv/cft_front.sv]
`timescale 1ns / 1ps
// cft_front: accepts text bytes, tracks quoting state and classifies each byte
// depends on cft_pkg and cft_if

module cft_front
    import cft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cft_text_if.sink          text,
    cft_cfg_if.sink           cfg,
    input  queue_status_t     qstat,
    output logic              push,
    output step_t             push_step
);

    logic [7:0] delimiter_reg;
    logic       in_quotes_reg;
    logic       in_quotes_next;
    logic       quote_pending_reg;
    logic       quote_pending_next;

    logic       accept;
    logic       have_byte;
    logic [7:0] byte_val;
    logic       delim_end;
    logic       iq_eff;
    logic       is_delim;
    logic       is_quote;

    assign text.ready = !qstat.full;
    assign cfg.ready  = 1'b1;
    assign accept     = text.valid && text.ready;
    assign is_delim   = (text.data_byte == delimiter_reg);
    assign is_quote   = (text.data_byte == QUOTE_CHAR);

    always_comb
    begin
        have_byte          = 1'b0;
        byte_val           = 8'd0;
        delim_end          = 1'b0;
        in_quotes_next     = in_quotes_reg;
        quote_pending_next = 1'b0;
        // a pending quote closes quoted mode unless this byte doubles it
        iq_eff             = quote_pending_reg ? 1'b0 : in_quotes_reg;

        if (quote_pending_reg && is_quote)
        begin
            have_byte = 1'b1;
            byte_val  = QUOTE_CHAR;
        end
        else
        begin
            in_quotes_next = iq_eff;
            if (!iq_eff && is_delim)
            begin
                delim_end = 1'b1;
            end
            else if (is_quote)
            begin
                if (!iq_eff)
                begin
                    in_quotes_next = 1'b1;
                end
                else if (text.is_last)
                begin
                    in_quotes_next = 1'b0;
                end
                else
                begin
                    quote_pending_next = 1'b1;
                end
            end
            else
            begin
                have_byte = 1'b1;
                byte_val  = text.data_byte;
            end
        end

        if (text.is_last)
        begin
            in_quotes_next     = 1'b0;
            quote_pending_next = 1'b0;
        end

        push_step.first.has_byte   = have_byte && !delim_end;
        push_step.first.field_byte = (have_byte && !delim_end) ? byte_val : 8'd0;
        push_step.first.field_end  = text.is_last || delim_end;
        push_step.first.line_end   = text.is_last && !is_delim;
        push_step.extra            = text.is_last && is_delim;

        push = accept && (text.is_last || delim_end || have_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg     <= DELIM_RESET;
            in_quotes_reg     <= 1'b0;
            quote_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                delimiter_reg <= cfg.delimiter;
            end
            if (accept)
            begin
                in_quotes_reg     <= in_quotes_next;
                quote_pending_reg <= quote_pending_next;
            end
        end
    end

endmodule

[sv/cft_queue.sv]
`timescale 1ns / 1ps
// cft_queue: short fifo of classified steps between front and back
// depends on cft_pkg

module cft_queue
    import cft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  step_t         push_step,
    input  logic          pop,
    output step_t         head,
    output queue_status_t qstat
);

    step_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[sv/cft_back.sv]
`timescale 1ns / 1ps
// cft_back: expands queued steps into result transfers through an output register
// depends on cft_pkg and cft_if

module cft_back
    import cft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  step_t         head,
    input  queue_status_t qstat,
    output logic          pop,
    cft_result_if.source  token
);

    logic    out_valid_reg;
    result_t out_reg;
    logic    extra_pending_reg;
    logic    can_load;

    assign can_load = !out_valid_reg || token.ready;
    assign pop      = can_load && !extra_pending_reg && !qstat.empty;

    assign token.valid      = out_valid_reg;
    assign token.has_byte   = out_reg.has_byte;
    assign token.field_byte = out_reg.field_byte;
    assign token.field_end  = out_reg.field_end;
    assign token.line_end   = out_reg.line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            extra_pending_reg <= 1'b0;
        end
        else if (can_load)
        begin
            if (extra_pending_reg)
            begin
                out_valid_reg     <= 1'b1;
                extra_pending_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg     <= !qstat.empty;
                extra_pending_reg <= !qstat.empty && head.extra;
            end
        end
    end

    // payload: the trailing empty field is a fixed result
    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (extra_pending_reg)
            begin
                out_reg.has_byte   <= 1'b0;
                out_reg.field_byte <= 8'd0;
                out_reg.field_end  <= 1'b1;
                out_reg.line_end   <= 1'b1;
            end
            else if (!qstat.empty)
            begin
                out_reg <= head.first;
            end
        end
    end

endmodule

[sv/csv_field_tokenizer.sv]
`timescale 1ns / 1ps
// csv_field_tokenizer: top level, front classifier, step queue and result back end
// depends on cft_pkg, cft_if, cft_front, cft_queue, cft_back
//
//  channel | dir | payload                                    | transfer
//  text    | in  | data_byte[7:0], is_last                    | valid && ready
//  token   | out | has_byte, field_byte[7:0], field_end, line_end | valid && ready
//  cfg     | in  | delimiter[7:0]                             | valid && ready
//
// one byte per cycle in while the step queue is not full; each byte gives zero,
// one or two results, the second (trailing empty field) issued as an extra back end transfer
// first result passes through the queue write and then the output register
// a four-entry step queue lets the front keep taking bytes while token stalls, until it is full
// reset: delimiter comma, outside quotes, queue and output register empty

module csv_field_tokenizer
    import cft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cft_text_if.sink      text,
    cft_cfg_if.sink       cfg,
    cft_result_if.source  token
);

    logic          push;
    step_t         push_step;
    logic          pop;
    step_t         head;
    queue_status_t qstat;

    cft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_step (push_step)
    );

    cft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_step (push_step),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    cft_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .token (token)
    );

endmodule
